// ----- design/ltd_pkg.sv -----
// Shared constants, codes and types of the lottery draw block.
// Used by every module in the design folder; depends on nothing else.

package ltd_pkg;

   localparam int MAX_JOBS             = 16;
   localparam int TICKETS_PER_PRIORITY = 10;

   localparam int PRIO_W   = 8;
   localparam int BURST_W  = 16;
   localparam int VALUE_W  = 16;
   localparam int TIME_W   = 20;
   localparam int STATUS_W = 3;
   localparam int JOBNUM_W = 5;
   localparam int LEFT_W   = 16;
   localparam int OPCODE_W = 2;

   localparam int JOB_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W     = $clog2(MAX_JOBS + 1);
   localparam int TKT_W     = $clog2(255 * TICKETS_PER_PRIORITY + 1);
   localparam int TOT_RAW_W = $clog2(255 * TICKETS_PER_PRIORITY * MAX_JOBS + 1);
   localparam int TOT_W     = (TOT_RAW_W > LEFT_W) ? TOT_RAW_W : LEFT_W;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_WINNER   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic retire_en;
      logic clear_all;
   } store_cmd_type;

   typedef struct packed {
      logic             hit;
      logic             miss;
      logic [JOB_W-1:0] idx;
      logic [TKT_W-1:0] tickets;
   } scan_stat_type;

   function automatic logic [TKT_W-1:0] tickets_of(input logic [PRIO_W-1:0] prio);
      tickets_of = TKT_W'(prio) * TKT_W'(TICKETS_PER_PRIORITY);
   endfunction

   function automatic logic [LEFT_W-1:0] sat_left(input logic [TOT_W-1:0] total);
      if (total > TOT_W'(65535)) begin
         sat_left = '1;
      end else begin
         sat_left = total[LEFT_W-1:0];
      end
   endfunction

endpackage

// ----- design/lottery_scheduler_draw_top.sv -----
// Lottery draw scheduler, top level. Jobs are loaded into a job memory, each
// owning ten tickets per priority point; a draw picks the first available job
// whose running ticket sum reaches the draw value, retires it and places it on
// the timeline. One item is handled at a time and every item gives one result,
// held in an output register so that the next item can be taken while it waits.
// A load, a clear or a draw answered at once passes through the result registers
// and then the output register; a draw that runs reads the job memory one entry
// a cycle through its single read port until it finds the winner or has read
// every loaded entry. Depends on ltd_pkg, ltd_job_store and ltd_draw_scan.

module lottery_scheduler_draw_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ltd_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [ltd_pkg::PRIO_W-1:0]     req_job_priority,
   input  logic [ltd_pkg::BURST_W-1:0]    req_job_burst,
   input  logic [ltd_pkg::VALUE_W-1:0]    req_draw_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ltd_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ltd_pkg::JOBNUM_W-1:0]   rsp_job_number,
   output logic [ltd_pkg::TIME_W-1:0]     rsp_start_time,
   output logic [ltd_pkg::TIME_W-1:0]     rsp_end_time,
   output logic [ltd_pkg::LEFT_W-1:0]     rsp_tickets_left
);
   import ltd_pkg::*;

   state_type           state_ff;
   state_type           state_in;
   logic [CNT_W-1:0]    loaded_ff;
   logic [CNT_W-1:0]    loaded_in;
   logic [TOT_W-1:0]    total_ff;
   logic [TOT_W-1:0]    total_in;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   now_in;
   logic [VALUE_W-1:0]  value_ff;
   logic [VALUE_W-1:0]  value_in;

   logic [STATUS_W-1:0] res_status_ff;
   logic [STATUS_W-1:0] res_status_in;
   logic [JOBNUM_W-1:0] res_job_ff;
   logic [JOBNUM_W-1:0] res_job_in;
   logic [TIME_W-1:0]   res_start_ff;
   logic [TIME_W-1:0]   res_start_in;
   logic [TIME_W-1:0]   res_end_ff;
   logic [TIME_W-1:0]   res_end_in;
   logic [LEFT_W-1:0]   res_left_ff;
   logic [LEFT_W-1:0]   res_left_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [JOBNUM_W-1:0] rsp_job_ff;
   logic [TIME_W-1:0]   rsp_start_ff;
   logic [TIME_W-1:0]   rsp_end_ff;
   logic [LEFT_W-1:0]   rsp_left_ff;
   logic                rsp_load;

   store_cmd_type       store_cmd;
   scan_stat_type       scan_stat;
   logic [JOB_W-1:0]    rd_addr;
   logic                rd_avail;
   logic [PRIO_W-1:0]   rd_prio;
   logic [BURST_W-1:0]  rd_burst;
   logic                scan_start;
   logic                scan_run;
   logic [TIME_W:0]     end_sum;
   logic [TIME_W-1:0]   end_sat;
   logic [TOT_W-1:0]    total_hit;

   ltd_job_store u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (store_cmd),
      .wr_idx     (loaded_ff[JOB_W-1:0]),
      .wr_prio    (req_job_priority),
      .wr_burst   (req_job_burst),
      .retire_idx (scan_stat.idx),
      .rd_addr    (rd_addr),
      .rd_avail   (rd_avail),
      .rd_prio    (rd_prio),
      .rd_burst   (rd_burst)
   );

   ltd_draw_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .run          (scan_run),
      .loaded_count (loaded_ff),
      .value        (value_ff),
      .rd_avail     (rd_avail),
      .rd_prio      (rd_prio),
      .rd_addr      (rd_addr),
      .stat         (scan_stat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign scan_run  = (state_ff == S_SCAN);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign end_sum   = {1'b0, now_ff} + (TIME_W + 1)'(rd_burst);
   assign end_sat   = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
   assign total_hit = total_ff - TOT_W'(scan_stat.tickets);

   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      total_in      = total_ff;
      now_in        = now_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      res_job_in    = res_job_ff;
      res_start_in  = res_start_ff;
      res_end_in    = res_end_ff;
      res_left_in   = res_left_ff;
      store_cmd     = '0;
      scan_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in      = S_DONE;
               res_status_in = ST_REJECTED;
               res_job_in    = '0;
               res_start_in  = '0;
               res_end_in    = '0;
               res_left_in   = sat_left(total_ff);
               case (req_opcode)
                  OP_LOAD: begin
                     if (loaded_ff >= CNT_W'(MAX_JOBS)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        store_cmd.wr_en = 1'b1;
                        total_in        = total_ff + TOT_W'(tickets_of(req_job_priority));
                        loaded_in       = loaded_ff + CNT_W'(1);
                        res_status_in   = ST_LOADED;
                        res_job_in      = JOBNUM_W'(loaded_in);
                        res_left_in     = sat_left(total_in);
                     end
                  end
                  OP_DRAW: begin
                     if (total_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else if ((req_draw_value == '0) ||
                                  (TOT_W'(req_draw_value) > total_ff)) begin
                        res_status_in = ST_REJECTED;
                     end else begin
                        value_in   = req_draw_value;
                        scan_start = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     store_cmd.clear_all = 1'b1;
                     loaded_in           = '0;
                     total_in            = '0;
                     now_in              = '0;
                     res_status_in       = ST_LOADED;
                     res_left_in         = '0;
                  end
                  default: begin
                     res_status_in = ST_REJECTED;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_stat.hit) begin
               store_cmd.retire_en = 1'b1;
               total_in            = total_hit;
               now_in              = end_sat;
               res_status_in       = ST_WINNER;
               res_job_in          = JOBNUM_W'(CNT_W'(scan_stat.idx) + CNT_W'(1));
               res_start_in        = now_ff;
               res_end_in          = end_sat;
               res_left_in         = sat_left(total_hit);
               state_in            = S_DONE;
            end else if (scan_stat.miss) begin
               res_status_in = ST_REJECTED;
               res_job_in    = '0;
               res_start_in  = '0;
               res_end_in    = '0;
               res_left_in   = sat_left(total_ff);
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         total_ff     <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         total_ff     <= total_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      res_job_ff    <= res_job_in;
      res_start_ff  <= res_start_in;
      res_end_ff    <= res_end_in;
      res_left_ff   <= res_left_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_job_ff    <= res_job_ff;
         rsp_start_ff  <= res_start_ff;
         rsp_end_ff    <= res_end_ff;
         rsp_left_ff   <= res_left_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_job_number   = rsp_job_ff;
   assign rsp_start_time   = rsp_start_ff;
   assign rsp_end_time     = rsp_end_ff;
   assign rsp_tickets_left = rsp_left_ff;

   a_retire_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      store_cmd.retire_en |-> (state_ff == S_SCAN))
      else $error("A job was retired outside a draw scan.");

   a_winner_drops_total: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && scan_stat.hit) |=> (total_ff < $past(total_ff)))
      else $error("A winning draw did not reduce the ticket total.");

   a_loaded_bounded: assert property (@(posedge clock) disable iff (reset)
      (loaded_ff <= CNT_W'(MAX_JOBS)))
      else $error("The loaded job count exceeds the table depth.");

   a_winner_numbered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_WINNER)) |-> (rsp_job_ff != '0))
      else $error("A winner result carries no job number.");

endmodule

// ----- design/ltd_job_store.sv -----
// Job memory holding priority and burst per entry, with a registered read port,
// and the per-entry availability flags. Depends on ltd_pkg.

module ltd_job_store (
   input  logic                         clock,
   input  logic                         reset,
   input  ltd_pkg::store_cmd_type       cmd,
   input  logic [ltd_pkg::JOB_W-1:0]    wr_idx,
   input  logic [ltd_pkg::PRIO_W-1:0]   wr_prio,
   input  logic [ltd_pkg::BURST_W-1:0]  wr_burst,
   input  logic [ltd_pkg::JOB_W-1:0]    retire_idx,
   input  logic [ltd_pkg::JOB_W-1:0]    rd_addr,
   output logic                         rd_avail,
   output logic [ltd_pkg::PRIO_W-1:0]   rd_prio,
   output logic [ltd_pkg::BURST_W-1:0]  rd_burst
);
   import ltd_pkg::*;

   logic [PRIO_W+BURST_W-1:0] job_mem [MAX_JOBS];
   logic [PRIO_W+BURST_W-1:0] rd_data_ff;
   logic                      rd_avail_ff;
   logic [MAX_JOBS-1:0]       avail_ff;
   logic [MAX_JOBS-1:0]       avail_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         job_mem[wr_idx] <= {wr_prio, wr_burst};
      end
      rd_data_ff  <= job_mem[rd_addr];
      rd_avail_ff <= avail_ff[rd_addr];
   end

   always_comb begin
      avail_in = avail_ff;
      if (cmd.clear_all) begin
         avail_in = '0;
      end else begin
         if (cmd.wr_en) begin
            avail_in[wr_idx] = 1'b1;
         end
         if (cmd.retire_en) begin
            avail_in[retire_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
      end else begin
         avail_ff <= avail_in;
      end
   end

   assign rd_avail = rd_avail_ff;
   assign rd_prio  = rd_data_ff[PRIO_W+BURST_W-1:BURST_W];
   assign rd_burst = rd_data_ff[BURST_W-1:0];

endmodule

// ----- design/ltd_draw_scan.sv -----
// Draw scanner: walks the job memory one entry a cycle in load order and keeps
// the running ticket sum until it reaches the draw value. Depends on ltd_pkg.

module ltd_draw_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         run,
   input  logic [ltd_pkg::CNT_W-1:0]    loaded_count,
   input  logic [ltd_pkg::VALUE_W-1:0]  value,
   input  logic                         rd_avail,
   input  logic [ltd_pkg::PRIO_W-1:0]   rd_prio,
   output logic [ltd_pkg::JOB_W-1:0]    rd_addr,
   output ltd_pkg::scan_stat_type       stat
);
   import ltd_pkg::*;

   logic [CNT_W-1:0] issue_ff;
   logic [CNT_W-1:0] issue_in;
   logic             look_vld_ff;
   logic [JOB_W-1:0] look_idx_ff;
   logic [TOT_W-1:0] sum_ff;
   logic [TOT_W-1:0] sum_in;
   logic             issuing;
   logic [TKT_W-1:0] tickets;
   logic [TOT_W-1:0] sum_next;

   assign issuing  = run && (issue_ff < loaded_count);
   assign rd_addr  = issue_ff[JOB_W-1:0];
   assign tickets  = tickets_of(rd_prio);
   assign sum_next = sum_ff + TOT_W'(tickets);

   always_comb begin
      stat.hit     = run && look_vld_ff && rd_avail && (sum_next >= TOT_W'(value));
      stat.miss    = run && !look_vld_ff && (issue_ff >= loaded_count);
      stat.idx     = look_idx_ff;
      stat.tickets = tickets;
   end

   always_comb begin
      issue_in = issue_ff;
      sum_in   = sum_ff;
      if (start) begin
         issue_in = '0;
         sum_in   = '0;
      end else begin
         if (issuing) begin
            issue_in = issue_ff + CNT_W'(1);
         end
         if (look_vld_ff && rd_avail) begin
            sum_in = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= '0;
         look_vld_ff <= 1'b0;
      end else begin
         issue_ff    <= issue_in;
         look_vld_ff <= issuing && !start;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      look_idx_ff <= issue_ff[JOB_W-1:0];
   end

endmodule
